[design/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg : shared types and constants for the SHA-1 digest engine
// Word layouts, command queue entry and the round constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

[design/sha1_queue.sv]
// ----------------------------------------------------------------------------
// sha1_queue : small word queue between front and back
// Holds accepted input words so the front keeps taking bytes while the
// back compresses.
// ----------------------------------------------------------------------------
module sha1_queue #(
    parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sha1_pkg::in_word_t push_word,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output sha1_pkg::in_word_t head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha1_pkg::in_word_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_reg] <= push_word;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop && not_empty)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overrun");
    a_full_nopush: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full) else $error("full queue lost a word");
    a_empty_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!not_empty && !push) |=> !not_empty) else $error("empty queue gained a word");
endmodule

[design/sha1_core.sv]
// ----------------------------------------------------------------------------
// sha1_core : block assembly, padding and 80-round compression
// Takes one queued word at a time, packs bytes into the schedule window,
// runs one round per cycle and streams out the digest.
// ----------------------------------------------------------------------------
module sha1_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  sha1_pkg::in_word_t  head,
    output logic                pop,
    output logic                out_valid,
    output sha1_pkg::out_word_t out_word,
    input  logic                out_stall
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t       state_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [6:0]   t_reg;
    logic         fin_reg;   // finishing: block under compression is padding
    logic         last_blk_reg;
    logic [2:0]   idx_reg;

    logic [31:0]  f, k, wt, wn, sum;
    logic [3:0]   wsel;
    logic [1:0]   bsel;

    assign wsel = fill_reg[5:2];
    assign bsel = fill_reg[1:0];

    // round function and schedule
    always_comb
    begin
        if (t_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1_pkg::K0;
        end
        else if (t_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K3;
        end
        wn  = sha1_pkg::rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        wt  = (t_reg < 7'd16) ? w_reg[0] : wn;
        sum = sha1_pkg::rotl(a_reg, 5) + f + e_reg + k + wt;
    end

    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign out_valid = (state_reg == S_EMIT);
    always_comb
    begin
        out_word.word_index = idx_reg;
        out_word.last_word  = (idx_reg == 3'd4);
        out_word.digest_word = h_reg[idx_reg];
    end

    // byte lane write helper: place byte at the current fill position
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] s,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[8*(3-s) +: 8] = b;
        return r;
    endfunction

    // schedule window (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (pop && head.kind == sha1_pkg::KIND_DATA)
            w_reg[wsel] <= put_byte(bsel == 2'd0 ? 32'd0 : w_reg[wsel], bsel, head.data_byte);
        else if (pop)
            w_reg[wsel] <= put_byte(bsel == 2'd0 ? 32'd0 : w_reg[wsel], bsel,
                                    sha1_pkg::PAD_BYTE);
        else if (state_reg == S_PAD && bsel == 2'd0)
            w_reg[wsel] <= 32'd0;
        else if (state_reg == S_LEN)
        begin
            w_reg[14] <= len_reg[63:32];
            w_reg[15] <= len_reg[31:0];
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
        end
    end

    // control, chaining and round variables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            h_reg[0]     <= sha1_pkg::H0;
            h_reg[1]     <= sha1_pkg::H1;
            h_reg[2]     <= sha1_pkg::H2;
            h_reg[3]     <= sha1_pkg::H3;
            h_reg[4]     <= sha1_pkg::H4;
            fill_reg     <= '0;
            len_reg      <= '0;
            t_reg        <= '0;
            fin_reg      <= 1'b0;
            last_blk_reg <= 1'b0;
            idx_reg      <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        if (head.kind == sha1_pkg::KIND_DATA)
                        begin
                            len_reg <= len_reg + 64'd8;
                            if (fill_reg == 6'd63)
                            begin
                                state_reg <= S_ROUND;
                                t_reg <= '0;
                                fin_reg <= 1'b0;
                                a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                                d_reg <= h_reg[3]; e_reg <= h_reg[4];
                            end
                        end
                        else
                        begin
                            fin_reg <= 1'b1;
                            last_blk_reg <= 1'b0;
                            if (fill_reg == 6'd63)
                            begin
                                // pad byte closes the block: compress it first
                                state_reg <= S_ROUND;
                                t_reg <= '0;
                                a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                                d_reg <= h_reg[3]; e_reg <= h_reg[4];
                            end
                            else
                                state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // mid-word: the pad word is complete, skip to the next word
                    if (bsel != 2'd0 && wsel != 4'd15)
                        fill_reg <= {wsel + 4'd1, 2'b00};
                    else if (bsel == 2'd0 && fill_reg == 6'd56)
                        state_reg <= S_LEN;
                    else if (wsel == 4'd15)
                    begin
                        // overflow block: compress it, then build the length block
                        state_reg <= S_ROUND;
                        t_reg <= '0;
                        last_blk_reg <= 1'b0;
                        a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                        d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    end
                    else
                        fill_reg <= fill_reg + 6'd4;
                end
                S_LEN:
                begin
                    state_reg <= S_ROUND;
                    t_reg <= '0;
                    last_blk_reg <= 1'b1;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                S_ROUND:
                begin
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= sha1_pkg::rotl(b_reg, 30);
                    b_reg <= a_reg;
                    a_reg <= sum;
                    t_reg <= t_reg + 7'd1;
                    if (t_reg == 7'd79)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    fill_reg <= '0;
                    if (!fin_reg)
                        state_reg <= S_IDLE;
                    else if (last_blk_reg)
                    begin
                        state_reg <= S_EMIT;
                        idx_reg <= '0;
                    end
                    else
                        state_reg <= S_PAD;
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4)
                        begin
                            state_reg <= S_IDLE;
                            h_reg[0] <= sha1_pkg::H0;
                            h_reg[1] <= sha1_pkg::H1;
                            h_reg[2] <= sha1_pkg::H2;
                            h_reg[3] <= sha1_pkg::H3;
                            h_reg[4] <= sha1_pkg::H4;
                            len_reg  <= '0;
                            fin_reg  <= 1'b0;
                            last_blk_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE)) else $error("pop while busy");
    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= 3'd4)) else $error("digest index overrun");
    a_round_t: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (t_reg < 7'd80)) else $error("round count overrun");
endmodule

[design/sha1_message_digest.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest : SHA-1 engine, one byte per input word
// Front queue takes bytes; back assembles, pads, compresses and emits.
// ----------------------------------------------------------------------------
// A data word is taken as soon as the back is free; every 64th byte starts an
// 80-round compression at one round per cycle followed by the chaining add,
// during which up to four further words wait in the queue.
// A finish word pads the block (zeroing the remaining words, then writing the
// length words), compresses one or two blocks and then presents five digest
// words, one per cycle while out_stall is low, most significant word first.
module sha1_message_digest #(
    parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sha1_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output sha1_pkg::out_word_t out_word
);
    logic               q_full, q_ne, q_pop;
    sha1_pkg::in_word_t q_head;

    assign in_stall = q_full;

    sha1_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_valid), .push_word(in_word), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    sha1_core u_core (
        .clk(clk), .rst_n(rst_n),
        .head_valid(q_ne), .head(q_head), .pop(q_pop),
        .out_valid(out_valid), .out_word(out_word), .out_stall(out_stall)
    );
endmodule
